### rtl/core/b64dec_pkg.sv
// shared constants, queue entry type and alphabet lookup for the base64 stream decoder
package b64dec_pkg;

	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperZ = 8'h5A;
	localparam logic [7:0] CharLowerA = 8'h61;
	localparam logic [7:0] CharLowerZ = 8'h7A;
	localparam logic [7:0] CharDigit0 = 8'h30;
	localparam logic [7:0] CharDigit9 = 8'h39;
	localparam logic [7:0] CharPlus   = 8'h2B;
	localparam logic [7:0] CharSlash  = 8'h2F;
	localparam logic [7:0] CharPad    = 8'h3D;

	localparam logic [5:0] LowerBase = 6'd26;
	localparam logic [5:0] DigitBase = 6'd52;
	localparam logic [5:0] ValPlus   = 6'd62;
	localparam logic [5:0] ValSlash  = 6'd63;

	// result queue: room for one full burst of three beats plus slack
	localparam int QueueDepth = 8;
	localparam int PtrW       = $clog2(QueueDepth);
	localparam int CntW       = $clog2(QueueDepth + 1);
	localparam int MaxBurst   = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_of_text;
	} entry_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t char_value(logic [7:0] c);
		sextet_t r;
		r.hit   = 1'b1;
		r.value = '0;
		if (c >= CharUpperA && c <= CharUpperZ) begin
			r.value = 6'(c - CharUpperA);
		end else if (c >= CharLowerA && c <= CharLowerZ) begin
			r.value = 6'(c - CharLowerA) + LowerBase;
		end else if (c >= CharDigit0 && c <= CharDigit9) begin
			r.value = 6'(c - CharDigit0) + DigitBase;
		end else if (c == CharPlus) begin
			r.value = ValPlus;
		end else if (c == CharSlash) begin
			r.value = ValSlash;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/core/base64_stream_decoder_top.sv
// base64 stream decoder: input register, one-pass group decode, result queue
// flow: an accepted character is held in the input register, then decoded and its beats written
//   into the result queue once the queue has room; the queue head drives the output directly
// throughput: one character per cycle unless stalled; the eight-entry result queue drains
//   one beat per cycle unless res_stall; input stalls only with under three free entries
// reset: arst_n clears pending values, count, padding flag, input valid and queue pointers
module base64_stream_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] text_char,
	input  logic       end_of_text,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       last_of_text
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// decoder state
	logic [17:0] pend_q;
	logic [1:0]  pcnt_q;
	logic        pad_q;

	// result queue
	b64dec_pkg::entry_t                  queue_q [b64dec_pkg::QueueDepth];
	logic [b64dec_pkg::PtrW-1:0]         wr_ptr_q;
	logic [b64dec_pkg::PtrW-1:0]         rd_ptr_q;
	logic [b64dec_pkg::CntW-1:0]         cnt_q;

	logic                                room;
	logic                                proc;
	logic                                accept;
	logic                                pop;
	b64dec_pkg::sextet_t                 sx;
	logic                                is_pad;
	logic [17:0]                         pend1;
	logic [1:0]                          pcnt1;
	logic                                pad1;
	logic [7:0]                          e_byte [b64dec_pkg::MaxBurst];
	logic [1:0]                          n1;
	logic [7:0]                          f_byte [2];
	logic [1:0]                          nf;
	b64dec_pkg::entry_t                  burst [b64dec_pkg::MaxBurst];
	logic [1:0]                          nb;

	assign room       = cnt_q <= b64dec_pkg::CntW'(b64dec_pkg::QueueDepth - b64dec_pkg::MaxBurst);
	assign proc       = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign accept     = char_valid && !char_stall;
	assign pop        = res_valid && !res_stall;

	// phase one: the character itself
	always_comb begin
		sx     = b64dec_pkg::char_value(char_s1);
		is_pad = char_s1 == b64dec_pkg::CharPad;
		pend1  = pend_q;
		pcnt1  = pcnt_q;
		pad1   = pad_q;
		n1     = 2'd0;
		e_byte[0] = '0;
		e_byte[1] = '0;
		e_byte[2] = '0;
		if (!pad_q) begin
			if (is_pad) begin
				pad1  = 1'b1;
				pend1 = '0;
				pcnt1 = 2'd0;
				if (pcnt_q == 2'd2) begin
					e_byte[0] = {pend_q[11:6], pend_q[5:4]};
					n1        = 2'd1;
				end else if (pcnt_q == 2'd3) begin
					e_byte[0] = {pend_q[17:12], pend_q[11:10]};
					e_byte[1] = {pend_q[9:6], pend_q[5:2]};
					n1        = 2'd2;
				end
			end else if (sx.hit) begin
				if (pcnt_q == 2'd3) begin
					e_byte[0] = {pend_q[17:12], pend_q[11:10]};
					e_byte[1] = {pend_q[9:6], pend_q[5:2]};
					e_byte[2] = {pend_q[1:0], sx.value};
					n1        = 2'd3;
					pend1     = '0;
					pcnt1     = 2'd0;
				end else begin
					pend1 = {pend_q[11:0], sx.value};
					pcnt1 = pcnt_q + 2'd1;
				end
			end
		end
	end

	// phase two: flush of a partial group at the end of the text
	always_comb begin
		nf        = 2'd0;
		f_byte[0] = '0;
		f_byte[1] = '0;
		if (last_s1) begin
			if (pcnt1 == 2'd2) begin
				f_byte[0] = {pend1[11:6], pend1[5:4]};
				nf        = 2'd1;
			end else if (pcnt1 == 2'd3) begin
				f_byte[0] = {pend1[17:12], pend1[11:10]};
				f_byte[1] = {pend1[9:6], pend1[5:2]};
				nf        = 2'd2;
			end
		end
	end

	// assemble the beats of this character; phase one bytes leave nothing to flush
	always_comb begin
		for (int i = 0; i < b64dec_pkg::MaxBurst; i++) begin
			burst[i] = '0;
		end
		nb = 2'd0;
		if (n1 != 2'd0) begin
			for (int i = 0; i < b64dec_pkg::MaxBurst; i++) begin
				burst[i].data_byte  = e_byte[i];
				burst[i].byte_valid = 2'(i) < n1;
			end
			nb = n1;
		end else if (nf != 2'd0) begin
			for (int i = 0; i < 2; i++) begin
				burst[i].data_byte  = f_byte[i];
				burst[i].byte_valid = 2'(i) < nf;
			end
			nb = nf;
		end
		if (last_s1) begin
			// no byte to carry the end mark: one empty beat does
			if (nb == 2'd0) begin
				nb = 2'd1;
			end
			burst[nb - 2'd1].last_of_text = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= text_char;
			last_s1 <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= 2'd0;
			pad_q  <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				pend_q <= '0;
				pcnt_q <= 2'd0;
				pad_q  <= 1'b0;
			end else begin
				pend_q <= pend1;
				pcnt_q <= pcnt1;
				pad_q  <= pad1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < b64dec_pkg::MaxBurst; i++) begin
				if (2'(i) < nb) begin
					queue_q[wr_ptr_q + b64dec_pkg::PtrW'(i)] <= burst[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + b64dec_pkg::PtrW'(nb);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + b64dec_pkg::PtrW'(1);
			end
			cnt_q <= cnt_q + (proc ? b64dec_pkg::CntW'(nb) : '0)
				- (pop ? b64dec_pkg::CntW'(1) : '0);
		end
	end

	assign res_valid    = cnt_q != '0;
	assign data_byte    = queue_q[rd_ptr_q].data_byte;
	assign byte_valid   = queue_q[rd_ptr_q].byte_valid;
	assign last_of_text = queue_q[rd_ptr_q].last_of_text;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= b64dec_pkg::CntW'(b64dec_pkg::QueueDepth))
		else $error("result queue count beyond depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s1 && !room))
		else $error("input stalled without a held character");

	a_text_close: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (pcnt_q == 2'd0 && !pad_q && pend_q == '0))
		else $error("decoder state not cleared after end of text");

	a_pad_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> (pcnt_q == 2'd0))
		else $error("values pending after padding");

	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |-> (nb != 2'd0))
		else $error("end of text produced no beat");

endmodule
